### rtl/scs1_pkg.sv
// Shared types, constants and keycode tables for the set 1 scancode decoder.
// No dependencies; imported by the decoder and the checker.
package scs1_pkg;

    // Special scancode bytes
    localparam logic [7:0] SC_BREAK_BIT  = 8'h80;
    localparam logic [7:0] SC_PREFIX_E0  = 8'hE0;
    localparam logic [7:0] SC_PREFIX_E1  = 8'hE1;
    localparam logic [7:0] SC_FAKE_LSHFT = 8'h2A;
    localparam logic [7:0] SC_FAKE_RSHFT = 8'h36;
    localparam logic [6:0] SC_PAUSE_HI   = 7'h1D;
    localparam logic [7:0] SC_PAUSE_LO   = 8'h45;

    // Keycodes with special handling
    localparam logic [6:0] KC_NONE  = 7'd0;
    localparam logic [6:0] KC_SHIFT = 7'd42;
    localparam logic [6:0] KC_CTRL  = 7'd29;
    localparam logic [6:0] KC_ALT   = 7'd56;
    localparam logic [6:0] KC_CAPS  = 7'd58;
    localparam logic [6:0] KC_PAUSE = 7'd119;

    // Table size (one entry per 7-bit code)
    localparam int TABLE_ENTRIES = 128;

    // E1 sequence phase
    localparam logic [1:0] E1_IDLE  = 2'd0;
    localparam logic [1:0] E1_FIRST = 2'd1;
    localparam logic [1:0] E1_LAST  = 2'd2;

    // Decoder state word, held in the state RAM
    typedef struct packed {
        logic       ext0_pending;
        logic [1:0] ext1_phase;
        logic [6:0] ext1_first;
        logic       shift_flag;
        logic       ctrl_flag;
        logic       alt_flag;
        logic       caps_flag;
    } t_dec_state;

    // One key event as queued for the output
    typedef struct packed {
        logic [6:0] key_code;
        logic       released;
        logic       shift_held;
        logic       ctrl_held;
        logic       alt_held;
        logic       caps_on;
    } t_key_event;

    // Plain codes: identity up to 82, then a few scattered keys
    function automatic logic [6:0] rom_normal(input logic [6:0] code);
        logic [6:0] kc;
        kc = KC_NONE;
        if (code <= 7'd82) begin
            kc = code;
        end else begin
            unique case (code)
                7'd83:   kc = 7'd84;
                7'd86:   kc = 7'd86;
                7'd87:   kc = 7'd87;
                7'd88:   kc = 7'd88;
                default: kc = KC_NONE;
            endcase
        end
        return kc;
    endfunction

    // E0-prefixed codes
    function automatic logic [6:0] rom_ext0(input logic [6:0] code);
        logic [6:0] kc;
        unique case (code)
            7'd29:   kc = 7'd97;
            7'd56:   kc = 7'd100;
            7'd71:   kc = 7'd102;
            7'd72:   kc = 7'd103;
            7'd73:   kc = 7'd104;
            7'd75:   kc = 7'd105;
            7'd77:   kc = 7'd106;
            7'd79:   kc = 7'd107;
            7'd80:   kc = 7'd108;
            7'd81:   kc = 7'd109;
            7'd82:   kc = 7'd110;
            7'd83:   kc = 7'd111;
            default: kc = KC_NONE;
        endcase
        return kc;
    endfunction

endpackage

### rtl/scs1_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scs1_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/scancode_set1_decoder.sv
// Top level of the set 1 scancode decoder: state RAM read-modify-write and output queue.
// Depends on scs1_pkg and scs1_ram.
//
//   channel   direction  handshake               payload
//   input     in         i_valid / o_stall       i_scan_byte
//   output    out        o_valid / i_stall       o_key_code, o_released, o_*_held, o_caps_on
//   config    in         i_cfg_we                i_cfg_wdata (enable)
//
// One byte per cycle sustained while o_stall is low; a byte's event is registered in stage 1
// and then in the output queue. The state word is read from RAM on acceptance and written back
// in the following cycle; a write in the same cycle as the next read is forwarded.
// Reset is synchronous and clears enable and the state (via a valid flag).
// The three-entry output queue absorbs output stalls; o_stall rises when it may fill.
module scancode_set1_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_scan_byte,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_key_code,
    output logic       o_released,
    output logic       o_shift_held,
    output logic       o_ctrl_held,
    output logic       o_alt_held,
    output logic       o_caps_on
);

    import scs1_pkg::*;

    localparam int OUT_DEPTH = 3;

    logic       in_take;
    logic       out_take;
    logic       r_enable;

    logic       r_s1_valid;
    logic [7:0] r_s1_byte;

    logic       r_state_valid;
    logic       r_fwd;
    t_dec_state r_last;
    t_dec_state ram_rdata;
    t_dec_state cur;
    t_dec_state n_state;

    logic       brk;
    logic [7:0] sc;
    logic [6:0] kc;
    logic       push;
    t_key_event event_new;

    t_key_event r_queue [OUT_DEPTH];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [1:0] r_count;
    logic [2:0] occupancy;

    // Handshakes
    assign occupancy = {1'b0, r_count} + {2'b00, r_s1_valid};
    assign o_stall   = (occupancy >= 3'(OUT_DEPTH));
    assign in_take   = i_valid && !o_stall;
    assign out_take  = o_valid && !i_stall;

    // Enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
        end else if (i_cfg_we) begin
            r_enable <= i_cfg_wdata;
        end
    end

    // Stage 1 capture; the RAM read is issued in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_scan_byte;
        end
    end

    // State RAM, one word
    scs1_ram #(
        .WIDTH ($bits(t_dec_state)),
        .DEPTH (1)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (1'b0),
        .i_wdata (n_state),
        .i_re    (in_take),
        .i_raddr (1'b0),
        .o_rdata (ram_rdata)
    );

    // Forwarding of a write that coincided with the read, and the written flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd         <= 1'b0;
            r_state_valid <= 1'b0;
        end else begin
            r_fwd <= in_take && r_s1_valid;
            if (r_s1_valid) begin
                r_state_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_last <= n_state;
        end
    end

    always_comb begin
        if (r_fwd) begin
            cur = r_last;
        end else if (r_state_valid) begin
            cur = ram_rdata;
        end else begin
            cur = '0;
        end
    end

    // Decode: prefix tracking, table lookup, modifier update
    always_comb begin
        brk = r_s1_byte[7]
              && ((cur.ext1_phase != E1_IDLE) || (r_s1_byte != SC_PREFIX_E1))
              && (cur.ext0_pending || (r_s1_byte != SC_PREFIX_E0));
        sc      = brk ? (r_s1_byte & ~SC_BREAK_BIT) : r_s1_byte;
        n_state = cur;
        kc      = KC_NONE;

        if (r_enable) begin
            priority if (cur.ext0_pending) begin
                n_state.ext0_pending = 1'b0;
                if ((sc != SC_FAKE_LSHFT) && (sc != SC_FAKE_RSHFT)) begin
                    kc = rom_ext0(sc[6:0]);
                end
            end else if (cur.ext1_phase == E1_LAST) begin
                n_state.ext1_phase = E1_IDLE;
                if ((cur.ext1_first == SC_PAUSE_HI) && (sc == SC_PAUSE_LO)) begin
                    kc = KC_PAUSE;
                end
            end else if (cur.ext1_phase == E1_FIRST) begin
                n_state.ext1_first = sc[6:0];
                n_state.ext1_phase = E1_LAST;
            end else if (sc == SC_PREFIX_E0) begin
                n_state.ext0_pending = 1'b1;
            end else if (sc == SC_PREFIX_E1) begin
                n_state.ext1_phase = E1_FIRST;
            end else begin
                kc = rom_normal(sc[6:0]);
            end

            // Modifiers; caps toggles on press only
            if (brk) begin
                if (kc == KC_SHIFT)     n_state.shift_flag = 1'b0;
                else if (kc == KC_CTRL) n_state.ctrl_flag  = 1'b0;
                else if (kc == KC_ALT)  n_state.alt_flag   = 1'b0;
            end else begin
                if (kc == KC_SHIFT)     n_state.shift_flag = 1'b1;
                else if (kc == KC_CTRL) n_state.ctrl_flag  = 1'b1;
                else if (kc == KC_ALT)  n_state.alt_flag   = 1'b1;
                else if (kc == KC_CAPS) n_state.caps_flag  = ~cur.caps_flag;
            end
        end

        push                 = r_s1_valid && r_enable && (kc != KC_NONE);
        event_new.key_code   = kc;
        event_new.released   = brk;
        event_new.shift_held = n_state.shift_flag;
        event_new.ctrl_held  = n_state.ctrl_flag;
        event_new.alt_held   = n_state.alt_flag;
        event_new.caps_on    = n_state.caps_flag;
    end

    // Output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == 2'(OUT_DEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
            end
            if (out_take) begin
                r_rd_ptr <= (r_rd_ptr == 2'(OUT_DEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
            end
            if (push && !out_take) begin
                r_count <= r_count + 2'd1;
            end else if (!push && out_take) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= event_new;
        end
    end

    assign o_valid      = (r_count != 2'd0);
    assign o_key_code   = r_queue[r_rd_ptr].key_code;
    assign o_released   = r_queue[r_rd_ptr].released;
    assign o_shift_held = r_queue[r_rd_ptr].shift_held;
    assign o_ctrl_held  = r_queue[r_rd_ptr].ctrl_held;
    assign o_alt_held   = r_queue[r_rd_ptr].alt_held;
    assign o_caps_on    = r_queue[r_rd_ptr].caps_on;

endmodule

### rtl/scs1_checker.sv
// Port-level checks for the set 1 scancode decoder, bound to the top level.
// Depends on scs1_pkg and scancode_set1_decoder.
module scs1_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_key_code,
    input logic       o_released,
    input logic       o_shift_held,
    input logic       o_ctrl_held
);

    import scs1_pkg::*;

    // Nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Only known keys are reported
    a_nonzero_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_key_code != KC_NONE))
        else $error("zero keycode reported");

    // Shift state follows its own press or release
    a_shift_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_key_code == KC_SHIFT)) |-> (o_shift_held == !o_released))
        else $error("shift state disagrees with shift transaction");

    // Ctrl state follows its own press or release
    a_ctrl_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_key_code == KC_CTRL)) |-> (o_ctrl_held == !o_released))
        else $error("ctrl state disagrees with ctrl transaction");

    // A stalled transaction holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_key_code) && $stable(o_released)))
        else $error("stalled output transaction changed");

endmodule

bind scancode_set1_decoder scs1_checker u_scs1_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_key_code   (o_key_code),
    .o_released   (o_released),
    .o_shift_held (o_shift_held),
    .o_ctrl_held  (o_ctrl_held)
);
